[rtl/core/ratt_pkg.sv]
package ratt_pkg;

    localparam logic [2:0] ACT_ADD     = 3'd0;
    localparam logic [2:0] ACT_XLATE   = 3'd1;
    localparam logic [2:0] ACT_LOOKUP  = 3'd2;
    localparam logic [2:0] ACT_RM_REC  = 3'd3;
    localparam logic [2:0] ACT_RM_ADDR = 3'd4;
    localparam logic [2:0] ACT_UPDATE  = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] location;
        logic [31:0] record;
    } entry_t;

    // per-cell shift control
    typedef struct packed {
        logic hold;
        logic load_prev;
        logic load_next;
        logic load_new;
        logic load_loc;
    } cell_ctl_t;

endpackage

[rtl/core/ratt_cell.sv]
module ratt_cell
(
    input  logic                 clk,
    input  ratt_pkg::cell_ctl_t  ctl,
    input  ratt_pkg::entry_t     prev_entry,
    input  ratt_pkg::entry_t     next_entry,
    input  ratt_pkg::entry_t     new_entry,
    output ratt_pkg::entry_t     entry
);

    ratt_pkg::entry_t entry_reg;
    ratt_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load_prev)
        begin
            entry_next = prev_entry;
        end
        else if (ctl.load_next)
        begin
            entry_next = next_entry;
        end
        else if (ctl.load_new)
        begin
            entry_next = new_entry;
        end
        else if (ctl.load_loc)
        begin
            entry_next.location = new_entry.location;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.hold)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

[rtl/core/range_address_translation_table.sv]
// Channel | Signals                                         | Direction
// --------+-------------------------------------------------+----------
// in      | in_valid/in_ready, action addr record_num       | to block
//         | region_size location                            |
// out     | out_valid/out_ready, status location_out        | from block
//         | base_out record_out size_out                    |
//
// One item at a time; each item is accepted while idle and then waits in the output
// register. Translate runs a binary search, one probe per cycle. Lookup, update and
// both removes scan one entry per cycle, then update and remove go through the apply
// state. Add runs the binary search, the record scan, a position walk and the apply
// state. Inserts and removals shift the cells at and above the affected position
// together in the apply state.
// Reset clears the entry count and the sequencer; table cells hold no reset.
// A result waits in the output register; in_ready stays low until taken.
module range_address_translation_table
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [31:0] addr,
    input  logic [31:0] record_num,
    input  logic [31:0] region_size,
    input  logic [31:0] location,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] location_out,
    output logic [31:0] base_out,
    output logic [31:0] record_out,
    output logic [31:0] size_out
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int SW = CW + 1;
    localparam int MW = CW + 2;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BSRCH  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_POS    = 3'd3;
    localparam logic [2:0] S_APPLY  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [2:0]        act_reg;
    ratt_pkg::entry_t  req_reg;
    logic [CW-1:0]     idx_reg, idx_next;
    logic signed [CW:0] lo_reg, lo_next, hi_reg, hi_next;
    logic              hit_reg, hit_next;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;
    logic              dup_reg, dup_next;
    logic [1:0]        st_reg, st_next;
    logic [31:0]       loc_o_reg, base_o_reg, rec_o_reg, size_o_reg;
    logic [31:0]       loc_o_next, base_o_next, rec_o_next, size_o_next;

    ratt_pkg::entry_t  ent [TABLE_ENTRIES];
    ratt_pkg::cell_ctl_t ctl [TABLE_ENTRIES];
    ratt_pkg::entry_t  zero_e;
    ratt_pkg::entry_t  cur;
    logic [IW-1:0]     rd_idx;
    logic signed [CW+1:0] mid_sum;
    logic signed [CW:0] mid;
    logic              in_rng, below;
    logic [31:0]       off;
    logic              do_ins, do_del, do_upd;

    assign zero_e = '0;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status = st_reg;
    assign location_out = loc_o_reg;
    assign base_out = base_o_reg;
    assign record_out = rec_o_reg;
    assign size_out = size_o_reg;

    // sum one bit wider so that lo + hi never overflows
    assign mid_sum = MW'(lo_reg) + MW'(hi_reg);
    assign mid = mid_sum[CW+1:1];

    always_comb
    begin
        if (state_reg == S_BSRCH)
        begin
            rd_idx = mid[IW-1:0];
        end
        else if (state_reg == S_POS)
        begin
            rd_idx = IW'(idx_reg - CW'(1));
        end
        else
        begin
            rd_idx = idx_reg[IW-1:0];
        end
    end

    assign cur    = ent[rd_idx];
    assign off    = req_reg.start - cur.start;
    assign below  = cur.start > req_reg.start;
    assign in_rng = !below && (off < cur.length);

    // row of cells; shift decisions per cell
    always_comb
    begin
        do_ins = (state_reg == S_APPLY) && (act_reg == ratt_pkg::ACT_ADD) && !dup_reg
                 && (count_reg < CW'(TABLE_ENTRIES)) && (req_reg.start != '0);
        do_del = (state_reg == S_APPLY) && hit_reg
                 && ((act_reg == ratt_pkg::ACT_RM_REC) || (act_reg == ratt_pkg::ACT_RM_ADDR));
        do_upd = (state_reg == S_APPLY) && hit_reg && (act_reg == ratt_pkg::ACT_UPDATE);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            ctl[i] = '0;
            ctl[i].hold = 1'b1;
            if (do_ins && (CW'(i) >= idx_reg) && (CW'(i) <= count_reg))
            begin
                ctl[i].hold = 1'b0;
                ctl[i].load_prev = (CW'(i) != idx_reg);
                ctl[i].load_new  = (CW'(i) == idx_reg);
            end
            if (do_del && (IW'(i) >= hit_idx_reg) && (CW'(i) + CW'(1) < count_reg))
            begin
                ctl[i].hold = 1'b0;
                ctl[i].load_next = 1'b1;
            end
            if (do_upd && (IW'(i) == hit_idx_reg))
            begin
                ctl[i].hold = 1'b0;
                ctl[i].load_loc = 1'b1;
            end
        end
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        ratt_cell u_cell
        (
            .clk        (clk),
            .ctl        (ctl[g]),
            .prev_entry ((g == 0) ? zero_e : ent[(g == 0) ? 0 : g - 1]),
            .next_entry ((g == TABLE_ENTRIES - 1) ? zero_e
                         : ent[(g == TABLE_ENTRIES - 1) ? g : g + 1]),
            .new_entry  (req_reg),
            .entry      (ent[g])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        dup_next     = dup_reg;
        st_next      = st_reg;
        loc_o_next   = loc_o_reg;
        base_o_next  = base_o_reg;
        rec_o_next   = rec_o_reg;
        size_o_next  = size_o_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next = '0;
                    lo_next  = '0;
                    hi_next  = $signed({1'b0, count_reg}) - SW'(1);
                    hit_next = 1'b0;
                    dup_next = 1'b0;
                    loc_o_next  = '0;
                    base_o_next = '0;
                    rec_o_next  = '0;
                    size_o_next = '0;
                    if ((action == ratt_pkg::ACT_XLATE) || (action == ratt_pkg::ACT_RM_ADDR)
                        || (action == ratt_pkg::ACT_ADD))
                    begin
                        if (addr == '0)
                        begin
                            st_next = ratt_pkg::ST_INVALID;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = (action == ratt_pkg::ACT_RM_ADDR) ? S_SCAN : S_BSRCH;
                        end
                    end
                    else if (action > ratt_pkg::ACT_UPDATE)
                    begin
                        st_next = ratt_pkg::ST_INVALID;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_BSRCH:
            begin
                if (lo_reg > hi_reg)
                begin
                    if (act_reg == ratt_pkg::ACT_ADD)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        st_next = ratt_pkg::ST_NOT_FOUND;
                        state_next = S_OUT;
                    end
                end
                else if (below)
                begin
                    hi_next = mid - SW'(1);
                end
                else if (!in_rng)
                begin
                    lo_next = mid + SW'(1);
                end
                else if (act_reg == ratt_pkg::ACT_ADD)
                begin
                    dup_next = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    st_next     = ratt_pkg::ST_OK;
                    base_o_next = cur.start;
                    loc_o_next  = cur.location + off;
                    rec_o_next  = cur.record;
                    size_o_next = cur.length - off;
                    state_next  = S_OUT;
                end
            end
            S_SCAN:
            begin
                if (idx_reg >= count_reg || hit_reg)
                begin
                    if (act_reg == ratt_pkg::ACT_ADD)
                    begin
                        if (dup_reg || hit_reg)
                        begin
                            st_next = ratt_pkg::ST_INVALID;
                            state_next = S_OUT;
                        end
                        else if (count_reg >= CW'(TABLE_ENTRIES))
                        begin
                            st_next = ratt_pkg::ST_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next = count_reg;
                            state_next = S_POS;
                        end
                    end
                    else if (!hit_reg)
                    begin
                        st_next = ratt_pkg::ST_NOT_FOUND;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        st_next = ratt_pkg::ST_OK;
                        state_next = S_APPLY;
                        if (act_reg == ratt_pkg::ACT_LOOKUP)
                        begin
                            loc_o_next  = ent[hit_idx_reg].location;
                            base_o_next = ent[hit_idx_reg].start;
                            rec_o_next  = ent[hit_idx_reg].record;
                            size_o_next = ent[hit_idx_reg].length;
                            state_next  = S_OUT;
                        end
                    end
                end
                else
                begin
                    if ((act_reg == ratt_pkg::ACT_RM_ADDR) ? in_rng
                        : (cur.record == req_reg.record))
                    begin
                        hit_next = 1'b1;
                        hit_idx_next = idx_reg[IW-1:0];
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            S_POS:
            begin
                // walk down until the entry below has a smaller start or the bottom is reached
                if (idx_reg == '0 || cur.start < req_reg.start)
                begin
                    st_next = ratt_pkg::ST_OK;
                    state_next = S_APPLY;
                end
                else
                begin
                    idx_next = idx_reg - CW'(1);
                end
            end
            S_APPLY:
            begin
                if (do_ins)
                begin
                    count_next = count_reg + CW'(1);
                end
                else if (do_del)
                begin
                    count_next = count_reg - CW'(1);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            act_reg          <= action;
            req_reg.start    <= addr;
            req_reg.length   <= region_size;
            req_reg.location <= location;
            req_reg.record   <= record_num;
        end
        idx_reg     <= idx_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        dup_reg     <= dup_next;
        st_reg      <= st_next;
        loc_o_reg   <= loc_o_next;
        base_o_reg  <= base_o_next;
        rec_o_reg   <= rec_o_next;
        size_o_reg  <= size_o_next;
    end

endmodule

[verif/ratt_checker.sv]
module ratt_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  action,
    input  logic [31:0] addr,
    input  logic [31:0] record_num,
    input  logic [31:0] region_size,
    input  logic [31:0] location,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [31:0] location_out,
    input  logic [31:0] base_out,
    input  logic [31:0] record_out,
    input  logic [31:0] size_out,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] loc;
        logic [31:0] base;
        logic [31:0] rec;
        logic [31:0] sz;
    } xlate_result_t;

    ratt_pkg::entry_t regions[16];
    int               n_regions;
    xlate_result_t    result_q[$];

    assign pending = result_q.size();

    // -1 below, +1 above, 0 inside
    function automatic int region_cmp(int i, logic [31:0] a);
        if (regions[i].start > a)
            return -1;
        if ({1'b0, a} - {1'b0, regions[i].start} >= {1'b0, regions[i].length})
            return 1;
        return 0;
    endfunction

    function automatic int search_addr(logic [31:0] a);
        int lo;
        int hi;
        int mid;
        int c;
        lo = 0;
        hi = n_regions - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            c = region_cmp(mid, a);
            if (c > 0)
                lo = mid + 1;
            else if (c < 0)
                hi = mid - 1;
            else
                return mid;
        end
        return -1;
    endfunction

    function automatic int search_record(logic [31:0] r);
        for (int i = 0; i < n_regions; i++)
            if (regions[i].record == r)
                return i;
        return -1;
    endfunction

    function automatic void remove_region(int k);
        for (int i = k; i + 1 < n_regions; i++)
            regions[i] = regions[i + 1];
        n_regions--;
    endfunction

    function automatic xlate_result_t apply_item(logic [2:0] act, logic [31:0] a,
        logic [31:0] r, logic [31:0] len, logic [31:0] loc);
        xlate_result_t res;
        int k;
        int pos;
        res = '0;
        res.st = ratt_pkg::ST_INVALID;
        case (act)
            ratt_pkg::ACT_ADD:
            begin
                if (a == 0 || search_record(r) >= 0 || search_addr(a) >= 0)
                    res.st = ratt_pkg::ST_INVALID;
                else if (n_regions >= 16)
                    res.st = ratt_pkg::ST_FULL;
                else
                begin
                    pos = 0;
                    for (int i = n_regions; i > 0; i--)
                        if (regions[i - 1].start < a)
                        begin
                            pos = i;
                            break;
                        end
                    for (int i = n_regions; i > pos; i--)
                        regions[i] = regions[i - 1];
                    regions[pos] = '{start: a, length: len, location: loc, record: r};
                    n_regions++;
                    res.st = ratt_pkg::ST_OK;
                end
            end
            ratt_pkg::ACT_XLATE:
            begin
                if (a != 0)
                begin
                    k = search_addr(a);
                    if (k < 0)
                        res.st = ratt_pkg::ST_NOT_FOUND;
                    else
                    begin
                        res.st = ratt_pkg::ST_OK;
                        res.base = regions[k].start;
                        res.loc = regions[k].location + (a - res.base);
                        res.rec = regions[k].record;
                        res.sz = regions[k].length - (a - res.base);
                    end
                end
            end
            ratt_pkg::ACT_LOOKUP:
            begin
                k = search_record(r);
                if (k < 0)
                    res.st = ratt_pkg::ST_NOT_FOUND;
                else
                begin
                    res.st = ratt_pkg::ST_OK;
                    res.loc = regions[k].location;
                    res.base = regions[k].start;
                    res.rec = regions[k].record;
                    res.sz = regions[k].length;
                end
            end
            ratt_pkg::ACT_RM_REC:
            begin
                k = search_record(r);
                if (k < 0)
                    res.st = ratt_pkg::ST_NOT_FOUND;
                else
                begin
                    remove_region(k);
                    res.st = ratt_pkg::ST_OK;
                end
            end
            ratt_pkg::ACT_RM_ADDR:
            begin
                if (a != 0)
                begin
                    res.st = ratt_pkg::ST_NOT_FOUND;
                    for (int i = 0; i < n_regions; i++)
                        if (region_cmp(i, a) == 0)
                        begin
                            remove_region(i);
                            res.st = ratt_pkg::ST_OK;
                            break;
                        end
                end
            end
            ratt_pkg::ACT_UPDATE:
            begin
                k = search_record(r);
                if (k < 0)
                    res.st = ratt_pkg::ST_NOT_FOUND;
                else
                begin
                    regions[k].location = loc;
                    res.st = ratt_pkg::ST_OK;
                end
            end
            default: res.st = ratt_pkg::ST_INVALID;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        xlate_result_t want;
        if (!rst_n)
        begin
            n_regions = 0;
            fail_count = 0;
            result_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                result_q.insert(result_q.size(),
                    apply_item(action, addr, record_num, region_size, location));
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected item st=%0d", $time, status);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (want != {status, location_out, base_out, record_out, size_out})
                    begin
                        $display("%0t: mismatch expected st=%0d loc=%h base=%h rec=%h sz=%h",
                            $time, want.st, want.loc, want.base, want.rec, want.sz);
                        $display("%0t:          actual   st=%0d loc=%h base=%h rec=%h sz=%h",
                            $time, status, location_out, base_out, record_out, size_out);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

[verif/tb_top.sv]
module tb_top;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  action;
    logic [31:0] addr;
    logic [31:0] record_num;
    logic [31:0] region_size;
    logic [31:0] location;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] location_out;
    logic [31:0] base_out;
    logic [31:0] record_out;
    logic [31:0] size_out;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          long_hold;

    // Small pools of starts and records so that random items hit existing
    // regions, duplicates and a full table often.
    logic [31:0] start_pool[8];
    logic [31:0] record_pool[8];

    range_address_translation_table dut (.*);

    ratt_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bound the run; a slow correct run is far below this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("range_address_translation_table regression: fail");
            $finish;
        end
    end

    // No gap half the time, short gaps mostly otherwise, and a rare long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off once the test is under way.
    initial
    begin
        int g;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            g = gap_len();
            if (g == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (g - 1) @(posedge clk);
            end
        end
    end

    // Present one item, hold it until taken, then at times idle a while.
    task automatic send_item(logic [2:0] act, logic [31:0] a, logic [31:0] r,
        logic [31:0] len, logic [31:0] loc);
        int g;
        in_valid <= 1'b1;
        action <= act;
        addr <= a;
        record_num <= r;
        region_size <= len;
        location <= loc;
        do
            @(posedge clk);
        while (!in_ready);
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic [2:0]  act;
        logic [31:0] a;
        logic [31:0] r;
        int          k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = '0;
        addr = '0;
        record_num = '0;
        region_size = '0;
        location = '0;
        long_hold = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table misses, zero address, overlap and wrap cases.
        send_item(ratt_pkg::ACT_XLATE, 32'h1000, 0, 0, 0);
        send_item(ratt_pkg::ACT_LOOKUP, 0, 32'd7, 0, 0);
        send_item(ratt_pkg::ACT_ADD, 32'h0, 32'd1, 32'h100, 32'h5000);
        send_item(ratt_pkg::ACT_ADD, 32'h1000, 32'd1, 32'h100, 32'h5000);
        send_item(ratt_pkg::ACT_ADD, 32'h1000, 32'd1, 32'h100, 32'h6000); // duplicate record
        send_item(ratt_pkg::ACT_ADD, 32'h1080, 32'd2, 32'h100, 32'h6000); // start inside region
        send_item(ratt_pkg::ACT_ADD, 32'h900, 32'd3, 32'h1000, 32'h7000); // overlaps ahead
        send_item(ratt_pkg::ACT_ADD, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFF0);
        send_item(ratt_pkg::ACT_ADD, 32'h2000, 32'd0, 32'h0, 32'h0);      // zero length
        send_item(ratt_pkg::ACT_XLATE, 32'h2000, 0, 0, 0);
        send_item(ratt_pkg::ACT_XLATE, 32'h10FF, 0, 0, 0);
        send_item(ratt_pkg::ACT_XLATE, 32'h1100, 0, 0, 0);
        send_item(ratt_pkg::ACT_XLATE, 32'hFFFF_FFFF, 0, 0, 0);           // location wraps
        send_item(ratt_pkg::ACT_XLATE, 32'h0, 0, 0, 0);
        send_item(ratt_pkg::ACT_LOOKUP, 0, 32'hFFFF_FFFF, 0, 0);
        send_item(ratt_pkg::ACT_UPDATE, 0, 32'd1, 0, 32'hFFFF_FFFF);
        send_item(ratt_pkg::ACT_UPDATE, 0, 32'd99, 0, 32'h1);
        send_item(ratt_pkg::ACT_LOOKUP, 0, 32'd1, 0, 0);
        send_item(ratt_pkg::ACT_RM_ADDR, 32'h0, 0, 0, 0);
        send_item(ratt_pkg::ACT_RM_ADDR, 32'h1010, 0, 0, 0);
        send_item(ratt_pkg::ACT_RM_ADDR, 32'h3000, 0, 0, 0);
        send_item(ratt_pkg::ACT_RM_REC, 0, 32'd0, 0, 0);
        send_item(ratt_pkg::ACT_RM_REC, 0, 32'd0, 0, 0);
        send_item(3'd6, 32'h1000, 0, 0, 0);
        send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        for (int i = 0; i < 8; i++)
        begin
            start_pool[i] = rand_word();
            record_pool[i] = $urandom_range(0, 3) == 0 ? rand_word() : 32'(i);
        end

        // Random: adds and other actions on mostly pooled starts and records.
        for (int n = 0; n < 1350; n++)
        begin
            if (n == 400)
                long_hold = 1'b1;
            if (n % 200 == 0)
                for (int i = 0; i < 8; i++)
                    start_pool[i] = rand_word();
            k = $urandom_range(0, 15);
            r = $urandom_range(0, 4) == 0 ? rand_word() : record_pool[$urandom_range(0, 7)];
            a = start_pool[$urandom_range(0, 7)] + ($urandom_range(0, 1) ? 32'h0
                : $urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
                a = rand_word();
            if ($urandom_range(0, 29) == 0)
                r = $urandom_range(8, 40);
            if (k < 6)
                act = ratt_pkg::ACT_ADD;
            else if (k < 15)
                act = 3'($urandom_range(1, 5));
            else
                act = 3'($urandom_range(0, 7));
            send_item(act, a, r,
                $urandom_range(0, 3) == 0 ? rand_word() : $urandom_range(0, 512),
                rand_word());
        end
        in_valid <= 1'b0;

        // let the checker take in the last item before draining
        @(posedge clk);
        wait (pending == 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("range_address_translation_table regression: pass");
        else
            $display("range_address_translation_table regression: fail");
        $finish;
    end

endmodule

[range_address_translation_table.f]
rtl/core/ratt_pkg.sv
rtl/core/ratt_cell.sv
rtl/core/range_address_translation_table.sv
verif/ratt_checker.sv
verif/tb_top.sv
